[design/rmp_pkg.sv]
`default_nettype none

package rmp_pkg;

  // default sizes of the count and offset counters
  localparam int COUNT_WIDTH_DEF  = 24;
  localparam int OFFSET_WIDTH_DEF = 32;

  // fixed field widths on the ports
  localparam int CFG_W    = 24;
  localparam int INDEX_W  = 24;
  localparam int OFFSET_W = 32;

  // protocol characters
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COLON = 8'h3a;

  // event codes
  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_ITEM_BEGIN = 3'd1;
  localparam logic [2:0] EV_VAL_BEGIN  = 3'd2;
  localparam logic [2:0] EV_VAL_END    = 3'd3;
  localparam logic [2:0] EV_ITEM_END   = 3'd4;
  localparam logic [2:0] EV_MSG_DONE   = 3'd5;
  localparam logic [2:0] EV_ERROR      = 3'd6;

  // item kinds
  localparam logic [1:0] KIND_ARRAY  = 2'd0;
  localparam logic [1:0] KIND_SIMPLE = 2'd1;
  localparam logic [1:0] KIND_BULK   = 2'd2;
  localparam logic [1:0] KIND_INT    = 2'd3;

  // register indexes on the config port
  localparam logic REG_MAX_ARRAY = 1'b0;
  localparam logic REG_MAX_BULK  = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] max_array_count;
    logic [CFG_W-1:0] max_bulk_length;
  } rmp_cfg_t;

  typedef struct packed {
    logic [2:0]          event_res;
    logic [1:0]          item_kind;
    logic                is_element;
    logic [INDEX_W-1:0]  element_index;
    logic [OFFSET_W-1:0] byte_offset;
  } rmp_result_t;

endpackage

`default_nettype wire

[design/rmp_cfg.sv]
`default_nettype none

module rmp_cfg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [2:0]       cfg_paddr,
  input  wire logic [31:0]      cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready,
  output rmp_pkg::rmp_cfg_t     cfg
);
  import rmp_pkg::*;

  logic [CFG_W-1:0] max_array_r;
  logic [CFG_W-1:0] max_bulk_r;
  logic             wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_array_r <= CFG_W'(1024);
      max_bulk_r  <= {CFG_W{1'b1}};
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        REG_MAX_ARRAY: max_array_r <= cfg_pwdata[CFG_W-1:0];
        REG_MAX_BULK:  max_bulk_r  <= cfg_pwdata[CFG_W-1:0];
        default:       max_bulk_r  <= max_bulk_r;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (cfg_paddr[2])
      REG_MAX_ARRAY: cfg_prdata = {{(32-CFG_W){1'b0}}, max_array_r};
      REG_MAX_BULK:  cfg_prdata = {{(32-CFG_W){1'b0}}, max_bulk_r};
      default:       cfg_prdata = '0;
    endcase
  end

  assign cfg.max_array_count = max_array_r;
  assign cfg.max_bulk_length = max_bulk_r;

endmodule

`default_nettype wire

[design/rmp_parser.sv]
`default_nettype none

module rmp_parser #(
  parameter int COUNT_WIDTH  = rmp_pkg::COUNT_WIDTH_DEF,
  parameter int OFFSET_WIDTH = rmp_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step_en,
  input  wire logic [7:0]        data_byte,
  input  wire rmp_pkg::rmp_cfg_t cfg,
  output rmp_pkg::rmp_result_t   result
);
  import rmp_pkg::*;

  localparam int CW    = COUNT_WIDTH;
  localparam int OW    = OFFSET_WIDTH;
  localparam int LIM_W = ((CW > CFG_W) ? CW : CFG_W) + 4;
  localparam int IDX_EXT_W = (CW > INDEX_W) ? CW : INDEX_W;
  localparam int OFF_EXT_W = (OW > OFFSET_W) ? OW : OFFSET_W;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_ARR_LEN   = 4'd1,
    PH_ARR_LF    = 4'd2,
    PH_ELEM      = 4'd3,
    PH_STR_FIRST = 4'd4,
    PH_STR_BODY  = 4'd5,
    PH_STR_LF    = 4'd6,
    PH_INT_FIRST = 4'd7,
    PH_INT_BODY  = 4'd8,
    PH_INT_LF    = 4'd9,
    PH_BULK_LEN  = 4'd10,
    PH_BULK_LF   = 4'd11,
    PH_BULK_DATA = 4'd12,
    PH_BULK_CR   = 4'd13,
    PH_BULK_LF2  = 4'd14
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [1:0]      kind_r, kind_nxt;
  logic            inarr_r, inarr_nxt;
  logic            neg_r, neg_nxt;
  logic            dseen_r, dseen_nxt;
  logic [CW-1:0]   acount_r, acount_nxt;
  logic [CW-1:0]   edone_r, edone_nxt;
  logic [CW-1:0]   blen_r, blen_nxt;
  logic [CW-1:0]   bseen_r, bseen_nxt;
  logic [OW-1:0]   moff_r, moff_nxt;

  logic            is_digit;
  logic            sc_ok;
  logic [1:0]      sc_kind;
  phase_t          sc_phase;
  logic [CW-1:0]   acc_base;
  logic [CFG_W-1:0] acc_lim;
  logic [LIM_W-1:0] acc_ext;
  logic [LIM_W-1:0] acc_v;
  logic            acc_over;
  logic [CW-1:0]   acc_new;
  logic [CW-1:0]   edone_inc;
  logic [CW-1:0]   bseen_inc;

  logic [2:0]      ev;
  logic [1:0]      okind;
  logic            oel;
  logic [CW-1:0]   oidx;
  logic [OW-1:0]   off;
  logic [OW-1:0]   moff_base;
  logic            fixed, err, done, finish;
  logic [IDX_EXT_W-1:0] idx_ext;
  logic [OFF_EXT_W-1:0] off_ext;

  // byte classes
  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);

  always_comb begin
    sc_ok    = 1'b1;
    sc_kind  = KIND_SIMPLE;
    sc_phase = PH_STR_FIRST;
    case (data_byte)
      CH_PLUS: begin
        sc_kind  = KIND_SIMPLE;
        sc_phase = PH_STR_FIRST;
      end
      CH_DOLLAR: begin
        sc_kind  = KIND_BULK;
        sc_phase = PH_BULK_LEN;
      end
      CH_COLON: begin
        sc_kind  = KIND_INT;
        sc_phase = PH_INT_FIRST;
      end
      default: sc_ok = 1'b0;
    endcase
  end

  // shared decimal accumulate and limit check for count and length
  assign acc_base = (phase_r == PH_ARR_LEN) ? acount_r : blen_r;
  assign acc_lim  = (phase_r == PH_ARR_LEN) ? cfg.max_array_count : cfg.max_bulk_length;
  assign acc_ext  = LIM_W'(acc_base);
  assign acc_v    = (acc_ext << 3) + (acc_ext << 1) + LIM_W'(data_byte[3:0]);
  assign acc_over = (acc_v > LIM_W'(acc_lim)) || (acc_v > LIM_W'({CW{1'b1}}));
  assign acc_new  = acc_v[CW-1:0];

  assign edone_inc = edone_r + CW'(1);
  assign bseen_inc = bseen_r + CW'(1);
  assign moff_base = (phase_r == PH_IDLE) ? '0 : moff_r;

  // next state and event for one byte
  always_comb begin
    phase_nxt  = phase_r;
    kind_nxt   = kind_r;
    inarr_nxt  = inarr_r;
    neg_nxt    = neg_r;
    dseen_nxt  = dseen_r;
    acount_nxt = acount_r;
    edone_nxt  = edone_r;
    blen_nxt   = blen_r;
    bseen_nxt  = bseen_r;
    moff_nxt   = moff_r;
    ev     = EV_NONE;
    okind  = kind_r;
    oel    = 1'b0;
    oidx   = '0;
    off    = moff_base;
    fixed  = 1'b0;
    err    = 1'b0;
    done   = 1'b0;
    finish = 1'b0;

    unique case (phase_r)
      PH_ARR_LEN: begin
        if (data_byte == CH_MINUS) begin
          if (dseen_r || neg_r) err = 1'b1;
          else neg_nxt = 1'b1;
        end else if (is_digit) begin
          dseen_nxt = 1'b1;
          if (!neg_r) begin
            if (acc_over) err = 1'b1;
            else acount_nxt = acc_new;
          end
        end else if (data_byte == CH_CR && dseen_r) begin
          phase_nxt = PH_ARR_LF;
        end else begin
          err = 1'b1;
        end
      end
      PH_ARR_LF: begin
        if (data_byte != CH_LF) begin
          err = 1'b1;
        end else if (neg_r || acount_r == '0) begin
          // null or empty array ends here
          ev    = EV_MSG_DONE;
          done  = 1'b1;
          fixed = 1'b1;
          okind = kind_r;
        end else begin
          phase_nxt = PH_ELEM;
          inarr_nxt = 1'b1;
          edone_nxt = '0;
        end
      end
      PH_ELEM: begin
        dseen_nxt = 1'b0;
        if (sc_ok) begin
          ev        = EV_ITEM_BEGIN;
          kind_nxt  = sc_kind;
          phase_nxt = sc_phase;
          if (sc_kind == KIND_BULK) blen_nxt = '0;
        end else begin
          err = 1'b1;
        end
      end
      PH_STR_FIRST, PH_STR_BODY: begin
        if (data_byte == CH_CR) begin
          ev        = EV_VAL_END;
          phase_nxt = PH_STR_LF;
        end else if (phase_r == PH_STR_FIRST) begin
          ev        = EV_VAL_BEGIN;
          phase_nxt = PH_STR_BODY;
        end
      end
      PH_INT_FIRST: begin
        if (data_byte == CH_MINUS || is_digit) begin
          ev        = EV_VAL_BEGIN;
          dseen_nxt = is_digit;
          phase_nxt = PH_INT_BODY;
        end else begin
          err = 1'b1;
        end
      end
      PH_INT_BODY: begin
        if (is_digit) begin
          dseen_nxt = 1'b1;
        end else if (data_byte == CH_CR && dseen_r) begin
          ev        = EV_VAL_END;
          phase_nxt = PH_INT_LF;
        end else begin
          err = 1'b1;
        end
      end
      PH_BULK_LEN: begin
        if (is_digit) begin
          if (acc_over) err = 1'b1;
          else blen_nxt = acc_new;
        end else if (data_byte == CH_CR && blen_r != '0) begin
          phase_nxt = PH_BULK_LF;
        end else begin
          err = 1'b1;
        end
      end
      PH_BULK_LF: begin
        if (data_byte == CH_LF) begin
          phase_nxt = PH_BULK_DATA;
          bseen_nxt = '0;
        end else begin
          err = 1'b1;
        end
      end
      PH_BULK_DATA: begin
        if (bseen_r == '0) ev = EV_VAL_BEGIN;
        bseen_nxt = bseen_inc;
        if (bseen_inc >= blen_r) phase_nxt = PH_BULK_CR;
      end
      PH_BULK_CR: begin
        if (data_byte == CH_CR) begin
          ev        = EV_VAL_END;
          phase_nxt = PH_BULK_LF2;
        end else begin
          err = 1'b1;
        end
      end
      PH_STR_LF, PH_INT_LF, PH_BULK_LF2: begin
        if (data_byte == CH_LF) finish = 1'b1;
        else err = 1'b1;
      end
      default: begin
        // idle: expect a type prefix
        off = '0;
        if (data_byte == CH_STAR) begin
          kind_nxt   = KIND_ARRAY;
          phase_nxt  = PH_ARR_LEN;
          acount_nxt = '0;
          neg_nxt    = 1'b0;
          dseen_nxt  = 1'b0;
          ev         = EV_ITEM_BEGIN;
        end else begin
          dseen_nxt = 1'b0;
          if (sc_ok) begin
            ev        = EV_ITEM_BEGIN;
            kind_nxt  = sc_kind;
            phase_nxt = sc_phase;
            if (sc_kind == KIND_BULK) blen_nxt = '0;
          end else begin
            err = 1'b1;
          end
        end
      end
    endcase

    // closing LF of a scalar: element end or message end
    if (finish) begin
      fixed = 1'b1;
      if (inarr_r) begin
        oidx      = edone_r;
        oel       = 1'b1;
        okind     = kind_r;
        edone_nxt = edone_inc;
        if (edone_inc >= acount_r) begin
          ev    = EV_MSG_DONE;
          done  = 1'b1;
          okind = KIND_ARRAY;
          oel   = 1'b0;
          oidx  = '0;
        end else begin
          ev        = EV_ITEM_END;
          kind_nxt  = KIND_ARRAY;
          phase_nxt = PH_ELEM;
        end
      end else begin
        ev    = EV_MSG_DONE;
        done  = 1'b1;
        okind = kind_r;
      end
    end

    if (!fixed) begin
      okind = kind_nxt;
      oel   = inarr_nxt;
      oidx  = inarr_nxt ? edone_nxt : '0;
    end

    // error or finished message returns to idle
    if (err || done) begin
      if (err) ev = EV_ERROR;
      phase_nxt  = PH_IDLE;
      kind_nxt   = KIND_ARRAY;
      inarr_nxt  = 1'b0;
      neg_nxt    = 1'b0;
      dseen_nxt  = 1'b0;
      acount_nxt = '0;
      edone_nxt  = '0;
      blen_nxt   = '0;
      bseen_nxt  = '0;
      moff_nxt   = '0;
    end else if (moff_base != {OW{1'b1}}) begin
      moff_nxt = moff_base + OW'(1);
    end else begin
      moff_nxt = moff_base;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      kind_r   <= KIND_ARRAY;
      inarr_r  <= 1'b0;
      neg_r    <= 1'b0;
      dseen_r  <= 1'b0;
      acount_r <= '0;
      edone_r  <= '0;
      blen_r   <= '0;
      bseen_r  <= '0;
      moff_r   <= '0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      kind_r   <= kind_nxt;
      inarr_r  <= inarr_nxt;
      neg_r    <= neg_nxt;
      dseen_r  <= dseen_nxt;
      acount_r <= acount_nxt;
      edone_r  <= edone_nxt;
      blen_r   <= blen_nxt;
      bseen_r  <= bseen_nxt;
      moff_r   <= moff_nxt;
    end
  end

  // result fields at port widths
  assign idx_ext = IDX_EXT_W'(oidx);
  assign off_ext = OFF_EXT_W'(off);

  assign result.event_res     = ev;
  assign result.item_kind     = okind;
  assign result.is_element    = oel;
  assign result.element_index = idx_ext[INDEX_W-1:0];
  assign result.byte_offset   = off_ext[OFFSET_W-1:0];

endmodule

`default_nettype wire

[design/resp_message_parser_core.sv]
`default_nettype none

// Byte-stream message parser. Each item on the in_ channel is one byte of
// the protocol stream and produces exactly one result item on the out_
// channel: an event code (item begin, value begin, value end, item end,
// message done, error or none) with the current item kind, the element
// flag and index, and the byte's offset in its message. One byte is taken
// every clock cycle unless the input stalls; the result appears in the cycle
// after the byte is taken, from an output register that takes the next result
// in the same cycle the previous result leaves; while a result waits unaccepted
// the input stalls. Throughput is set by the single parse step between the
// input and that register. The user must write the two limit registers on the
// cfg_ port only while no byte is in flight; the block does not enforce this.
module resp_message_parser_core #(
  parameter int COUNT_WIDTH  = rmp_pkg::COUNT_WIDTH_DEF,
  parameter int OFFSET_WIDTH = rmp_pkg::OFFSET_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // [7:0] data_byte
  // result items
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,    // [2:0] event_res, [26:3] element_index,
                                         // [58:27] byte_offset, rest zero
  output logic [2:0]       out_tuser,    // [1:0] item_kind, [2] is_element
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import rmp_pkg::*;

  rmp_cfg_t    cfg;
  rmp_result_t step_res;
  rmp_result_t res_r;
  logic        out_valid_r;
  logic        in_acc;

  rmp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // accept while the result register is empty or being emptied
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  rmp_parser #(
    .COUNT_WIDTH  (COUNT_WIDTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (in_acc),
    .data_byte (in_tdata),
    .cfg       (cfg),
    .result    (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, res_r.byte_offset, res_r.element_index, res_r.event_res};
  assign out_tuser  = {res_r.is_element, res_r.item_kind};

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import rmp_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [2:0] ADDR_MAX_ARRAY = {REG_MAX_ARRAY, 2'b00};
  localparam logic [2:0] ADDR_MAX_BULK  = {REG_MAX_BULK, 2'b00};

  // parser states of the predictor
  typedef enum logic [3:0] {
    ST_IDLE, ST_CNT, ST_CNT_LF, ST_ELEM, ST_SIMPLE_FIRST, ST_SIMPLE_BODY,
    ST_SIMPLE_LF, ST_INT_FIRST, ST_INT_BODY, ST_INT_LF, ST_BLEN, ST_BLEN_LF,
    ST_BDATA, ST_BDATA_CR, ST_BDATA_LF
  } parse_state_t;

  // predicts one event per byte and checks the events that come out
  class parse_event_board;
    rmp_result_t pending_events[$];
    int unsigned mismatches;
    logic [CFG_W-1:0] max_arr;
    logic [CFG_W-1:0] max_bulk;
    parse_state_t st;
    logic [1:0] cur_kind;
    logic in_array;
    logic neg_cnt;
    logic have_digit;
    logic [INDEX_W-1:0] arr_cnt;
    logic [INDEX_W-1:0] elems;
    logic [INDEX_W-1:0] blen;
    logic [INDEX_W-1:0] bseen;
    logic [OFFSET_W-1:0] msg_off;

    function new();
      mismatches = 0;
      max_arr = 24'd1024;
      max_bulk = '1;
      restart();
    endfunction

    function void restart();
      st = ST_IDLE;
      cur_kind = KIND_ARRAY;
      in_array = 1'b0;
      neg_cnt = 1'b0;
      have_digit = 1'b0;
      arr_cnt = '0;
      elems = '0;
      blen = '0;
      bseen = '0;
      msg_off = '0;
    endfunction

    function bit is_numeral(logic [7:0] b);
      return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    // start of a string, bulk or integer; arrays are handled by the caller
    function bit open_scalar(logic [7:0] b);
      have_digit = 1'b0;
      if (b == CH_PLUS) begin
        cur_kind = KIND_SIMPLE;
        st = ST_SIMPLE_FIRST;
        return 1'b1;
      end
      if (b == CH_DOLLAR) begin
        cur_kind = KIND_BULK;
        st = ST_BLEN;
        blen = '0;
        return 1'b1;
      end
      if (b == CH_COLON) begin
        cur_kind = KIND_INT;
        st = ST_INT_FIRST;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_byte(logic [7:0] b);
      rmp_result_t r;
      logic [35:0] acc;
      logic fixed;
      logic err;
      logic done;
      logic finish;
      r = '0;
      r.event_res = EV_NONE;
      r.byte_offset = msg_off;
      fixed = 1'b0;
      err = 1'b0;
      done = 1'b0;
      finish = 1'b0;
      case (st)
        ST_CNT: begin
          if (b == CH_MINUS) begin
            if (have_digit || neg_cnt) err = 1'b1;
            else neg_cnt = 1'b1;
          end else if (is_numeral(b)) begin
            have_digit = 1'b1;
            if (!neg_cnt) begin
              acc = arr_cnt * 36'd10 + (b - CH_ZERO);
              if (acc > max_arr) err = 1'b1;
              else arr_cnt = acc[INDEX_W-1:0];
            end
          end else if (b == CH_CR && have_digit) begin
            st = ST_CNT_LF;
          end else begin
            err = 1'b1;
          end
        end
        ST_CNT_LF: begin
          if (b != CH_LF) begin
            err = 1'b1;
          end else if (neg_cnt || arr_cnt == 0) begin
            // null or empty array closes the message here
            r.event_res = EV_MSG_DONE;
            done = 1'b1;
            fixed = 1'b1;
          end else begin
            st = ST_ELEM;
            in_array = 1'b1;
            elems = '0;
          end
        end
        ST_ELEM: begin
          if (open_scalar(b)) r.event_res = EV_ITEM_BEGIN;
          else err = 1'b1;
        end
        ST_SIMPLE_FIRST, ST_SIMPLE_BODY: begin
          if (b == CH_CR) begin
            r.event_res = EV_VAL_END;
            st = ST_SIMPLE_LF;
          end else if (st == ST_SIMPLE_FIRST) begin
            r.event_res = EV_VAL_BEGIN;
            st = ST_SIMPLE_BODY;
          end
        end
        ST_INT_FIRST: begin
          if (b == CH_MINUS || is_numeral(b)) begin
            r.event_res = EV_VAL_BEGIN;
            have_digit = is_numeral(b);
            st = ST_INT_BODY;
          end else begin
            err = 1'b1;
          end
        end
        ST_INT_BODY: begin
          if (is_numeral(b)) begin
            have_digit = 1'b1;
          end else if (b == CH_CR && have_digit) begin
            r.event_res = EV_VAL_END;
            st = ST_INT_LF;
          end else begin
            err = 1'b1;
          end
        end
        ST_BLEN: begin
          if (is_numeral(b)) begin
            acc = blen * 36'd10 + (b - CH_ZERO);
            if (acc > max_bulk) err = 1'b1;
            else blen = acc[INDEX_W-1:0];
          end else if (b == CH_CR && blen != 0) begin
            st = ST_BLEN_LF;
          end else begin
            err = 1'b1;
          end
        end
        ST_BLEN_LF: begin
          if (b == CH_LF) begin
            st = ST_BDATA;
            bseen = '0;
          end else begin
            err = 1'b1;
          end
        end
        ST_BDATA: begin
          if (bseen == 0) r.event_res = EV_VAL_BEGIN;
          bseen = bseen + 1'b1;
          if (bseen >= blen) st = ST_BDATA_CR;
        end
        ST_BDATA_CR: begin
          if (b == CH_CR) begin
            r.event_res = EV_VAL_END;
            st = ST_BDATA_LF;
          end else begin
            err = 1'b1;
          end
        end
        ST_SIMPLE_LF, ST_INT_LF, ST_BDATA_LF: begin
          if (b == CH_LF) finish = 1'b1;
          else err = 1'b1;
        end
        default: begin
          r.byte_offset = '0;
          msg_off = '0;
          if (b == CH_STAR) begin
            cur_kind = KIND_ARRAY;
            st = ST_CNT;
            arr_cnt = '0;
            neg_cnt = 1'b0;
            have_digit = 1'b0;
            r.event_res = EV_ITEM_BEGIN;
          end else if (open_scalar(b)) begin
            r.event_res = EV_ITEM_BEGIN;
          end else begin
            err = 1'b1;
          end
        end
      endcase

      // closing LF of a value: end of element or of the whole message
      if (finish) begin
        fixed = 1'b1;
        if (in_array) begin
          r.element_index = elems;
          r.is_element = 1'b1;
          r.item_kind = cur_kind;
          elems = elems + 1'b1;
          if (elems >= arr_cnt) begin
            r.event_res = EV_MSG_DONE;
            done = 1'b1;
            r.item_kind = KIND_ARRAY;
            r.is_element = 1'b0;
            r.element_index = '0;
          end else begin
            r.event_res = EV_ITEM_END;
            cur_kind = KIND_ARRAY;
            st = ST_ELEM;
          end
        end else begin
          r.event_res = EV_MSG_DONE;
          done = 1'b1;
          r.item_kind = cur_kind;
        end
      end

      if (!fixed) begin
        r.item_kind = cur_kind;
        r.is_element = in_array;
        r.element_index = in_array ? elems : '0;
      end

      if (err) begin
        r.event_res = EV_ERROR;
        restart();
      end else if (done) begin
        restart();
      end else if (msg_off != '1) begin
        msg_off = msg_off + 1'b1;
      end
      pending_events = {pending_events, r};
    endfunction

    function void report(string what, rmp_result_t want, rmp_result_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%s: exp ev=%0d kind=%0d el=%0d idx=%0d off=%0d,%s", what, want.event_res,
                 want.item_kind, want.is_element, want.element_index, want.byte_offset,
                 $sformatf(" got ev=%0d kind=%0d el=%0d idx=%0d off=%0d", got.event_res,
                           got.item_kind, got.is_element, got.element_index,
                           got.byte_offset));
      end
    endfunction

    function void check_event(logic [63:0] tdata, logic [2:0] tuser);
      rmp_result_t got;
      rmp_result_t want;
      got.event_res = tdata[2:0];
      got.element_index = tdata[26:3];
      got.byte_offset = tdata[58:27];
      got.item_kind = tuser[1:0];
      got.is_element = tuser[2];
      want = '0;
      if (pending_events.size() == 0) begin
        report("unexpected event", want, got);
      end else begin
        want = pending_events.pop_front();
        if (got.event_res !== want.event_res || got.item_kind !== want.item_kind ||
            got.is_element !== want.is_element ||
            got.element_index !== want.element_index ||
            got.byte_offset !== want.byte_offset) begin
          report("event mismatch", want, got);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [63:0] out_tdata;
  logic [2:0] out_tuser;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  parse_event_board sb;
  logic [7:0] byte_stream[$];
  logic [CFG_W-1:0] cur_max_arr;
  logic [CFG_W-1:0] cur_max_bulk;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  int unsigned hold_reqs;
  int unsigned hold_served;
  int unsigned quiet_cycles = 0;

  resp_message_parser_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    out_tready = 1'b0;
    hold_served = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_served) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_served++;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata);
      if (out_tvalid && out_tready) sb.check_event(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // stream builders
  function automatic void append_byte(logic [7:0] b);
    byte_stream = {byte_stream, b};
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endfunction

  function automatic void push_crlf();
    append_byte(CH_CR);
    append_byte(CH_LF);
  endfunction

  function automatic void push_line(string s);
    push_str(s);
    push_crlf();
  endfunction

  function automatic void push_dec(int unsigned n);
    push_str($sformatf("%0d", n));
  endfunction

  function automatic void gen_scalar();
    int unsigned n;
    int unsigned lim;
    logic [7:0] b;
    case ($urandom_range(2))
      0: begin
        append_byte(CH_PLUS);
        n = $urandom_range(6);
        repeat (n) begin
          do b = 8'($urandom_range(255)); while (b == CH_CR);
          append_byte(b);
        end
        push_crlf();
      end
      1: begin
        append_byte(CH_COLON);
        if ($urandom_range(1)) append_byte(CH_MINUS);
        push_dec($urandom_range(99999));
        push_crlf();
      end
      default: begin
        lim = (cur_max_bulk < 8) ? cur_max_bulk : 8;
        n = $urandom_range(1, lim);
        append_byte(CH_DOLLAR);
        push_dec(n);
        push_crlf();
        repeat (n) append_byte(8'($urandom_range(255)));
        push_crlf();
      end
    endcase
  endfunction

  function automatic void gen_message();
    int unsigned lim;
    int unsigned n;
    if ($urandom_range(99) < 55) begin
      append_byte(CH_STAR);
      if ($urandom_range(7) == 0) begin
        // null array
        append_byte(CH_MINUS);
        push_dec($urandom_range(3000));
        push_crlf();
      end else begin
        lim = (cur_max_arr < 5) ? cur_max_arr : 5;
        n = $urandom_range(lim);
        push_dec(n);
        push_crlf();
        repeat (n) gen_scalar();
      end
    end else begin
      gen_scalar();
    end
  endfunction

  function automatic void gen_broken();
    int unsigned start;
    int unsigned cut;
    start = byte_stream.size();
    case ($urandom_range(3))
      0: begin
        append_byte(CH_STAR);
        push_dec(cur_max_arr + 1 + $urandom_range(50));
        push_crlf();
      end
      1: begin
        append_byte(CH_DOLLAR);
        push_dec(cur_max_bulk + 1 + $urandom_range(50));
        push_crlf();
      end
      2: begin
        gen_message();
        byte_stream[$urandom_range(start, byte_stream.size() - 1)] = 8'($urandom_range(255));
      end
      default: begin
        gen_message();
        cut = $urandom_range(start + 1, byte_stream.size() - 1);
        while (byte_stream.size() > cut) void'(byte_stream.pop_back());
      end
    endcase
  endfunction

  // driver tasks
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_stream(input bit with_hold);
    int unsigned sent;
    sent = 0;
    while (byte_stream.size() != 0) begin
      if (with_hold && sent == 40) hold_reqs++;
      send_byte(byte_stream.pop_front());
      sent++;
    end
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [CFG_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= {8'($urandom_range(255)), value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_MAX_ARRAY) begin
      sb.max_arr = value;
      cur_max_arr = value;
    end else begin
      sb.max_bulk = value;
      cur_max_bulk = value;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] arr_lim, input logic [CFG_W-1:0] bulk_lim,
                           input int unsigned sidle, input int unsigned ridle,
                           input bit with_hold, input int unsigned nbytes);
    int unsigned pick;
    drain();
    cfg_write(ADDR_MAX_ARRAY, arr_lim);
    cfg_write(ADDR_MAX_BULK, bulk_lim);
    snd_idle_pct = sidle;
    rcv_idle_pct = ridle;
    while (byte_stream.size() < nbytes) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        gen_message();
      end else if (pick < 85) begin
        gen_broken();
      end else begin
        repeat ($urandom_range(1, 4)) append_byte(8'($urandom_range(255)));
      end
    end
    send_stream(with_hold);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    hold_reqs = 0;
    snd_idle_pct = 33;
    rcv_idle_pct = 77;
    cur_max_arr = 24'd1024;
    cur_max_bulk = '1;
    sb = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed cases at the reset limits
    push_line("+OK");
    push_line("+");                       // empty simple string
    push_line(":-42");
    push_line(":0");
    push_line("*0");                      // empty array
    push_line("*-99999999");              // null array, count not limited
    push_line("*2");
    push_line("$3");
    append_byte(8'h00);
    append_byte(8'hff);
    append_byte(CH_CR);
    push_crlf();
    push_line(":7");
    push_line("*1");
    push_str("*");                        // nested array
    push_str("x");                        // unknown prefix
    push_str("*");                        // count without digits
    append_byte(CH_CR);
    push_str(":-");                       // integer without digits
    append_byte(CH_CR);
    push_str("*1-");                      // sign after a digit
    push_str("*--");                      // second sign
    push_str("$0");                       // zero bulk length
    append_byte(CH_CR);
    push_str("$-");                       // negative bulk length
    push_str("*1025");                    // count over limit
    push_str("$16777216");                // length over limit
    push_str("+a");                       // missing LF
    append_byte(CH_CR);
    push_str("X");
    push_line("$1");                      // missing CR after bulk data
    push_str("ab");
    send_stream(1'b0);

    // random phases, limit extremes first
    run_phase('1, '1, 33, 77, 1'b0, 175);
    run_phase('0, 24'd1, 77, 33, 1'b0, 175);
    run_phase(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 12)), 77, 33, 1'b0, 175);
    run_phase(CFG_W'($urandom_range(3, 5000)), CFG_W'($urandom_range(5, 100000)), 0, 0,
              1'b1, 175);

    drain();
    if (sb.mismatches == 0 && sb.pending_events.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
